// ===== hdl/trot_gait_foot_targets_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the trot gait foot target generator
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef TROT_GAIT_FOOT_TARGETS_ASSERT_SVH
`define TROT_GAIT_FOOT_TARGETS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TGFT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TGFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tgft_pkg.sv =====
// ----------------------------------------------------------------------------
// tgft_pkg
// Shared types, register codes, reset values and constants of the trot
// gait foot target generator.
// ----------------------------------------------------------------------------
package tgft_pkg;

    // Default geometry of the phase accumulator and the quarter-wave table.
    localparam int PHASE_BITS_DEFAULT = 16;
    localparam int SINE_DEPTH_DEFAULT = 256;

    // Configuration port widths.
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    // Leg index of the final result of a tick (right back).
    localparam logic [1:0] LEG_LAST = 2'd3;

    // Register reset values.
    localparam logic signed [15:0] STANDING_HEIGHT_RST = -16'sd18350;
    localparam logic [14:0] LIFT_HEIGHT_RST    = 15'd3277;
    localparam logic [15:0] STRIDE_GAIN_RST    = 16'd6554;
    localparam logic [14:0] SIDE_OFFSET_RST    = 15'd6554;
    localparam logic [15:0] YAW_GAIN_RST       = 16'd3277;
    localparam logic [15:0] PHASE_STEP_RST     = 16'd2621;
    localparam logic [14:0] MOVE_THRESHOLD_RST = 15'd41;

    // Odd polynomial for the sine table: Q30 coefficients, Q32 argument.
    localparam longint SINE_C1 = 64'sd1686629713;
    localparam longint SINE_C3 = -64'sd693598669;
    localparam longint SINE_C5 = 64'sd85569306;
    localparam longint SINE_C7 = -64'sd5026995;
    localparam longint SINE_C9 = 64'sd172271;
    localparam longint Q32_ONE = 64'sd1 <<< 32;
    localparam longint Q46_ONE = 64'sd1 <<< 46;

    // Register index (byte address divided by four).
    typedef enum logic [2:0] {
        REG_STANDING_HEIGHT = 3'd0,
        REG_LIFT_HEIGHT     = 3'd1,
        REG_STRIDE_GAIN     = 3'd2,
        REG_SIDE_OFFSET     = 3'd3,
        REG_YAW_GAIN        = 3'd4,
        REG_PHASE_STEP      = 3'd5,
        REG_MOVE_THRESHOLD  = 3'd6
    } reg_idx_t;

    // Current register contents.
    typedef struct packed {
        logic signed [15:0] standing_height;
        logic [14:0]        lift_height;
        logic [15:0]        stride_gain;
        logic [14:0]        side_offset;
        logic [15:0]        yaw_gain;
        logic [15:0]        phase_step;
        logic [14:0]        move_threshold;
    } cfg_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_TRIG,
        ST_MUL_CF,
        ST_MUL_CS,
        ST_MUL_XG,
        ST_MUL_YG,
        ST_MUL_LIFT,
        ST_LIFT,
        ST_EMIT
    } ctrl_state_t;

    // Operand selection of the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_YAW,
        MUL_CF,
        MUL_CS,
        MUL_XG,
        MUL_YG,
        MUL_LIFT
    } mul_op_t;

    // Where the registered product is written back.
    typedef enum logic [2:0] {
        DST_NONE,
        DST_YAW,
        DST_CF,
        DST_CS,
        DST_XA,
        DST_YA,
        DST_LIFT
    } prod_dst_t;

    // Command bundle from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       phase_upd;
        logic       trig_load;
        mul_op_t    mul_op;
        prod_dst_t  dst;
        logic       load_out;
        logic [1:0] leg;
    } dp_cmd_t;

endpackage

// ===== hdl/trot_gait_foot_targets.sv =====
// ----------------------------------------------------------------------------
// trot_gait_foot_targets: trot gait foot target generator
// The four leg beats of a command follow the phase update, the trig lookup and the six
// products of the one shared multiplier. The next command is taken only once all four
// legs of a tick are loaded. Reset clears phase and state; registers take reset values.
// ----------------------------------------------------------------------------
`include "trot_gait_foot_targets_assert.svh"

module trot_gait_foot_targets
#(
    parameter int PHASE_BITS       = tgft_pkg::PHASE_BITS_DEFAULT,
    parameter int SINE_TABLE_DEPTH = tgft_pkg::SINE_DEPTH_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Command beat.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [47:0]                         s_tdata,  // speed_fwd, speed_side, yaw_rate
    // Leg result beat.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,  // foot_x, foot_y, foot_z
    output logic [1:0]                          m_tuser,  // leg_index
    output logic                                m_tlast,  // last_leg
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tgft_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [tgft_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [tgft_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    tgft_pkg::cfg_t    cfg;
    tgft_pkg::dp_cmd_t cmd;

    // Configuration registers.
    tgft_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    tgft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Arithmetic and result register.
    tgft_dp
    #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (s_tdata),
        .out_data (m_tdata),
        .out_leg  (m_tuser),
        .out_last (m_tlast)
    );

    // A taken command blocks further commands until its last leg is loaded.
    `TGFT_ASSERT_NEXT(a_one_tick, s_tvalid && s_tready, !s_tready, "second command taken mid-tick")

    // The last marker only travels with the right back leg.
    `TGFT_ASSERT_SAME(a_last_leg, m_tvalid && m_tlast, m_tuser == tgft_pkg::LEG_LAST,
        "last marker on wrong leg")

    // Legs leave in order without gaps once the sequencer is emitting.
    `TGFT_ASSERT_NEXT(a_leg_order, m_tvalid && m_tready && !m_tlast,
        m_tvalid && (m_tuser == $past(m_tuser) + 2'd1), "leg sequence broken")

    // While waiting for a command, only the final leg may still be pending.
    `TGFT_ASSERT_SAME(a_idle_out, s_tready, !m_tvalid || m_tlast,
        "idle with an unfinished tick")

endmodule

// ===== hdl/tgft_regs.sv =====
// ----------------------------------------------------------------------------
// tgft_regs
// Configuration register file behind a simple APB-style port.
// ----------------------------------------------------------------------------
module tgft_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tgft_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [tgft_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [tgft_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output tgft_pkg::cfg_t                      cfg
);

    tgft_pkg::cfg_t     cfg_reg;
    tgft_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    // The port never waits.
    assign pready  = 1'b1;
    assign reg_idx = tgft_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    // Register writes; only the low bits of each register's width are kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.standing_height <= tgft_pkg::STANDING_HEIGHT_RST;
            cfg_reg.lift_height     <= tgft_pkg::LIFT_HEIGHT_RST;
            cfg_reg.stride_gain     <= tgft_pkg::STRIDE_GAIN_RST;
            cfg_reg.side_offset     <= tgft_pkg::SIDE_OFFSET_RST;
            cfg_reg.yaw_gain        <= tgft_pkg::YAW_GAIN_RST;
            cfg_reg.phase_step      <= tgft_pkg::PHASE_STEP_RST;
            cfg_reg.move_threshold  <= tgft_pkg::MOVE_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tgft_pkg::REG_STANDING_HEIGHT: cfg_reg.standing_height <= pwdata[15:0];
                tgft_pkg::REG_LIFT_HEIGHT:     cfg_reg.lift_height     <= pwdata[14:0];
                tgft_pkg::REG_STRIDE_GAIN:     cfg_reg.stride_gain     <= pwdata[15:0];
                tgft_pkg::REG_SIDE_OFFSET:     cfg_reg.side_offset     <= pwdata[14:0];
                tgft_pkg::REG_YAW_GAIN:        cfg_reg.yaw_gain        <= pwdata[15:0];
                tgft_pkg::REG_PHASE_STEP:      cfg_reg.phase_step      <= pwdata[15:0];
                tgft_pkg::REG_MOVE_THRESHOLD:  cfg_reg.move_threshold  <= pwdata[14:0];
                default:                       ;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_idx)
            tgft_pkg::REG_STANDING_HEIGHT: prdata = 32'(cfg_reg.standing_height);
            tgft_pkg::REG_LIFT_HEIGHT:     prdata = {17'd0, cfg_reg.lift_height};
            tgft_pkg::REG_STRIDE_GAIN:     prdata = {16'd0, cfg_reg.stride_gain};
            tgft_pkg::REG_SIDE_OFFSET:     prdata = {17'd0, cfg_reg.side_offset};
            tgft_pkg::REG_YAW_GAIN:        prdata = {16'd0, cfg_reg.yaw_gain};
            tgft_pkg::REG_PHASE_STEP:      prdata = {16'd0, cfg_reg.phase_step};
            tgft_pkg::REG_MOVE_THRESHOLD:  prdata = {17'd0, cfg_reg.move_threshold};
            default:                       prdata = '0;
        endcase
    end

endmodule

// ===== hdl/tgft_ctrl.sv =====
// ----------------------------------------------------------------------------
// tgft_ctrl
// Sequencer: takes one command beat, walks the shared multiplier through
// its six products, then hands the four leg results to the output register.
// ----------------------------------------------------------------------------
module tgft_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output tgft_pkg::dp_cmd_t   cmd
);

    tgft_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]            leg_reg, leg_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  load;

    assign m_tvalid = out_valid_reg;

    // State, leg counter and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tgft_pkg::ST_IDLE;
            leg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            leg_reg       <= leg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        leg_next     = leg_reg;
        s_tready     = 1'b0;
        load         = 1'b0;
        cmd.capture   = 1'b0;
        cmd.phase_upd = 1'b0;
        cmd.trig_load = 1'b0;
        cmd.mul_op    = tgft_pkg::MUL_NONE;
        cmd.dst       = tgft_pkg::DST_NONE;
        cmd.leg       = leg_reg;

        case (state_reg)
            tgft_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                leg_next    = '0;
                if (s_tvalid)
                begin
                    state_next = tgft_pkg::ST_PHASE;
                end
            end
            tgft_pkg::ST_PHASE:
            begin
                cmd.phase_upd = 1'b1;
                state_next    = tgft_pkg::ST_TRIG;
            end
            tgft_pkg::ST_TRIG:
            begin
                cmd.trig_load = 1'b1;
                cmd.mul_op    = tgft_pkg::MUL_YAW;
                state_next    = tgft_pkg::ST_MUL_CF;
            end
            tgft_pkg::ST_MUL_CF:
            begin
                cmd.dst    = tgft_pkg::DST_YAW;
                cmd.mul_op = tgft_pkg::MUL_CF;
                state_next = tgft_pkg::ST_MUL_CS;
            end
            tgft_pkg::ST_MUL_CS:
            begin
                cmd.dst    = tgft_pkg::DST_CF;
                cmd.mul_op = tgft_pkg::MUL_CS;
                state_next = tgft_pkg::ST_MUL_XG;
            end
            tgft_pkg::ST_MUL_XG:
            begin
                cmd.dst    = tgft_pkg::DST_CS;
                cmd.mul_op = tgft_pkg::MUL_XG;
                state_next = tgft_pkg::ST_MUL_YG;
            end
            tgft_pkg::ST_MUL_YG:
            begin
                cmd.dst    = tgft_pkg::DST_XA;
                cmd.mul_op = tgft_pkg::MUL_YG;
                state_next = tgft_pkg::ST_MUL_LIFT;
            end
            tgft_pkg::ST_MUL_LIFT:
            begin
                cmd.dst    = tgft_pkg::DST_YA;
                cmd.mul_op = tgft_pkg::MUL_LIFT;
                state_next = tgft_pkg::ST_LIFT;
            end
            tgft_pkg::ST_LIFT:
            begin
                cmd.dst    = tgft_pkg::DST_LIFT;
                state_next = tgft_pkg::ST_EMIT;
            end
            tgft_pkg::ST_EMIT:
            begin
                // Load the next leg whenever the output register is free.
                load = !out_valid_reg || m_tready;
                if (load)
                begin
                    leg_next = leg_reg + 2'd1;
                    if (leg_reg == tgft_pkg::LEG_LAST)
                    begin
                        state_next = tgft_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = tgft_pkg::ST_IDLE;
            end
        endcase

        cmd.load_out = load;

        // The output register drains independently of the sequencer.
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

// ===== hdl/tgft_dp.sv =====
// ----------------------------------------------------------------------------
// tgft_dp
// Datapath: phase accumulator, quarter-wave sine lookup, one shared
// multiplier with product write-back, and the leg result register.
// ----------------------------------------------------------------------------
module tgft_dp
#(
    parameter int PHASE_BITS       = tgft_pkg::PHASE_BITS_DEFAULT,
    parameter int SINE_TABLE_DEPTH = tgft_pkg::SINE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  tgft_pkg::dp_cmd_t   cmd,
    input  tgft_pkg::cfg_t      cfg,
    input  logic [47:0]         in_data,
    output logic [47:0]         out_data,
    output logic [1:0]          out_leg,
    output logic                out_last
);

    localparam int FRAC_BITS = PHASE_BITS - 2;
    localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_BITS = FRAC_BITS + IDX_BITS;
    localparam logic [PROD_BITS-1:0]  DEPTH_W = PROD_BITS'(SINE_TABLE_DEPTH);
    localparam logic [IDX_BITS-1:0]   DEPTH_I = IDX_BITS'(SINE_TABLE_DEPTH);
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << FRAC_BITS;

    // One table entry: sin(pi/2 * k / depth) in Q16, clamped to 0..65536.
    function automatic logic [16:0] sine_entry(input int k);
        longint          u;
        longint unsigned uu;
        longint          u2;
        longint          p;
        longint          v;
        if (k >= SINE_TABLE_DEPTH)
        begin
            return 17'd65536;
        end
        u  = (longint'(k) <<< 32) / SINE_TABLE_DEPTH;
        uu = unsigned'(u) * unsigned'(u);
        u2 = longint'(uu >> 32);
        p  = tgft_pkg::SINE_C9;
        p  = tgft_pkg::SINE_C7 + (p * u2) / tgft_pkg::Q32_ONE;
        p  = tgft_pkg::SINE_C5 + (p * u2) / tgft_pkg::Q32_ONE;
        p  = tgft_pkg::SINE_C3 + (p * u2) / tgft_pkg::Q32_ONE;
        p  = tgft_pkg::SINE_C1 + (p * u2) / tgft_pkg::Q32_ONE;
        v  = (p * u) / tgft_pkg::Q46_ONE;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65536)
        begin
            v = 65536;
        end
        return 17'(v);
    endfunction

    // Signed division by a power of two, rounding toward zero.
    function automatic logic signed [51:0] div_pow2(input logic signed [51:0] p,
                                                    input int unsigned sh);
        logic signed [51:0] bias;
        bias = p[51] ? signed'((52'(1) << sh) - 52'(1)) : '0;
        return (p + bias) >>> sh;
    endfunction

    // Magnitude of a 16-bit signed command; the most negative value gives 32768.
    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] w;
        w = 17'(v);
        return v[15] ? unsigned'(-w) : unsigned'(w);
    endfunction

    // Saturate to the 16-bit coordinate range.
    function automatic logic [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767)
        begin
            return 16'h7fff;
        end
        if (v < -24'sd32768)
        begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    // Constant quarter-wave table.
    logic [16:0] sine_rom [SINE_TABLE_DEPTH + 1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    logic signed [15:0]     fwd_reg, side_reg, yaw_reg;
    logic                   moving_reg;
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_inc;
    logic                   moving;
    logic signed [17:0]     sin_reg, cos_reg;
    logic signed [51:0]     prod_reg;
    logic signed [33:0]     mul_a;
    logic signed [17:0]     mul_b;
    logic signed [33:0]     cf_reg, cs_reg;
    logic signed [20:0]     yaw_term_reg, xa_reg, ya_reg;
    logic [14:0]            lift_reg;
    logic [16:0]            sin_mag;
    logic [15:0]            out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]             out_leg_reg;
    logic                   out_last_reg;

    // Phase increment scaled to the accumulator width.
    if (PHASE_BITS >= 16)
    begin : g_inc_wide
        assign phase_inc = PHASE_BITS'(cfg.phase_step) << (PHASE_BITS - 16);
    end
    else
    begin : g_inc_narrow
        assign phase_inc = PHASE_BITS'(cfg.phase_step >> (16 - PHASE_BITS));
    end

    // The gait runs while any command magnitude is above the threshold.
    assign moving = (mag17(fwd_reg)  > {2'b00, cfg.move_threshold}) ||
                    (mag17(side_reg) > {2'b00, cfg.move_threshold}) ||
                    (mag17(yaw_reg)  > {2'b00, cfg.move_threshold});

    // Command capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            fwd_reg  <= in_data[15:0];
            side_reg <= in_data[31:16];
            yaw_reg  <= in_data[47:32];
        end
    end

    // Phase accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (cmd.phase_upd)
        begin
            phase_reg <= moving ? phase_reg + phase_inc : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.phase_upd)
        begin
            moving_reg <= moving;
        end
    end

    // Sine and cosine lookups: lane 0 uses the phase, lane 1 the phase plus
    // a quarter turn.
    logic [PHASE_BITS-1:0] trig_ph [2];
    logic [1:0]            quad    [2];
    logic [PROD_BITS-1:0]  idx_w   [2];
    logic [IDX_BITS-1:0]   idx     [2];
    logic [IDX_BITS-1:0]   addr    [2];
    logic signed [17:0]    trig_val[2];

    assign trig_ph[0] = phase_reg;
    assign trig_ph[1] = phase_reg + QUARTER;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            quad[i]     = trig_ph[i][PHASE_BITS-1 -: 2];
            idx_w[i]    = ({IDX_BITS'(0), trig_ph[i][FRAC_BITS-1:0]} * DEPTH_W) >> FRAC_BITS;
            idx[i]      = idx_w[i][IDX_BITS-1:0];
            addr[i]     = quad[i][0] ? DEPTH_I - idx[i] : idx[i];
            trig_val[i] = quad[i][1] ? -signed'({1'b0, sine_rom[addr[i]]})
                                     :  signed'({1'b0, sine_rom[addr[i]]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.trig_load)
        begin
            sin_reg <= trig_val[0];
            cos_reg <= trig_val[1];
        end
    end

    assign sin_mag = sin_reg[17] ? 17'(-sin_reg) : 17'(sin_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_op)
            tgft_pkg::MUL_YAW:
            begin
                mul_a = 34'(yaw_reg);
                mul_b = signed'({2'b00, cfg.yaw_gain});
            end
            tgft_pkg::MUL_CF:
            begin
                mul_a = 34'(cos_reg);
                mul_b = 18'(fwd_reg);
            end
            tgft_pkg::MUL_CS:
            begin
                mul_a = 34'(cos_reg);
                mul_b = 18'(side_reg);
            end
            tgft_pkg::MUL_XG:
            begin
                mul_a = cf_reg;
                mul_b = signed'({2'b00, cfg.stride_gain});
            end
            tgft_pkg::MUL_YG:
            begin
                mul_a = cs_reg;
                mul_b = signed'({2'b00, cfg.stride_gain});
            end
            tgft_pkg::MUL_LIFT:
            begin
                mul_a = signed'({17'd0, sin_mag});
                mul_b = signed'({3'b000, cfg.lift_height});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Registered product, written back to its destination in the following cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.dst)
            tgft_pkg::DST_YAW:  yaw_term_reg <= 21'(div_pow2(prod_reg, 12));
            tgft_pkg::DST_CF:   cf_reg       <= prod_reg[33:0];
            tgft_pkg::DST_CS:   cs_reg       <= prod_reg[33:0];
            tgft_pkg::DST_XA:   xa_reg       <= 21'(div_pow2(prod_reg, 28));
            tgft_pkg::DST_YA:   ya_reg       <= 21'(div_pow2(prod_reg, 28));
            tgft_pkg::DST_LIFT: lift_reg     <= prod_reg[30:16];
            default:            ;
        endcase
    end

    // Per-leg sums. The half-turn legs see sine and cosine negated, so the
    // motion terms flip sign; the right legs take the yaw term and the side
    // offset with the opposite sign to the left legs.
    logic               right_leg, half_turn, lift_on;
    logic signed [23:0] x_sum, y_sum, z_sum, side_w;

    assign right_leg = cmd.leg[0];
    assign half_turn = cmd.leg[0] ^ cmd.leg[1];
    assign side_w    = 24'(signed'({1'b0, cfg.side_offset}));
    assign lift_on   = moving_reg && (half_turn ? (sin_reg < 0) : (sin_reg > 0));

    always_comb
    begin
        x_sum = (half_turn ? 24'(xa_reg) : -24'(xa_reg)) +
                (right_leg ? 24'(yaw_term_reg) : -24'(yaw_term_reg));
        y_sum = (half_turn ? 24'(ya_reg) : -24'(ya_reg)) +
                (right_leg ? -side_w : side_w);
        z_sum = 24'(cfg.standing_height) +
                (lift_on ? 24'(signed'({1'b0, lift_reg})) : 24'sd0);
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_x_reg    <= sat16(x_sum);
            out_y_reg    <= sat16(y_sum);
            out_z_reg    <= sat16(z_sum);
            out_leg_reg  <= cmd.leg;
            out_last_reg <= (cmd.leg == tgft_pkg::LEG_LAST);
        end
    end

    assign out_data = {out_z_reg, out_y_reg, out_x_reg};
    assign out_leg  = out_leg_reg;
    assign out_last = out_last_reg;

endmodule

// ===== test/trot_gait_foot_targets_tb.sv =====
// ----------------------------------------------------------------------------
// trot_gait_foot_targets_tb
// Self-checking bench for the trot gait foot target generator. Command beats
// are fed from a queue with random gaps. Each accepted command is run through
// a local gait predictor that yields four expected leg beats. Leg beats are
// taken with random back-pressure and compared field by field. Registers are
// rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module trot_gait_foot_targets_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    localparam int PH_W  = tgft_pkg::PHASE_BITS_DEFAULT;
    localparam int DEPTH = tgft_pkg::SINE_DEPTH_DEFAULT;

    // Odd polynomial of the quarter-wave table: Q30 coefficients.
    localparam longint POLY_C1 = 64'sd1686629713;
    localparam longint POLY_C3 = -64'sd693598669;
    localparam longint POLY_C5 = 64'sd85569306;
    localparam longint POLY_C7 = -64'sd5026995;
    localparam longint POLY_C9 = 64'sd172271;
    localparam longint ONE_Q12 = 64'sd1 <<< 12;
    localparam longint ONE_Q16 = 64'sd1 <<< 16;
    localparam longint ONE_Q28 = 64'sd1 <<< 28;
    localparam longint ONE_Q32 = 64'sd1 <<< 32;
    localparam longint ONE_Q46 = 64'sd1 <<< 46;

    // Register slot past the end of the map; writes to it must be ignored.
    localparam logic [2:0] REG_SPARE = 3'd7;

    // Cycles allowed after the last leg beat before registers change.
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_TICKS   = 26;

    typedef struct {
        logic [1:0]         leg;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               last;
    } foot_target_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // speed_fwd, speed_side, yaw_rate
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;       // foot_x, foot_y, foot_z
    logic [1:0]  m_tuser;       // leg_index
    logic        m_tlast;       // last_leg
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [tgft_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [tgft_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [tgft_pkg::CFG_DATA_BITS-1:0] prdata;
    logic        pready;

    // Predictor state: register copy, phase accumulator and sine table.
    tgft_pkg::cfg_t gait_cfg;
    logic [15:0]    gait_phase = '0;
    int unsigned    sin_rom [0:DEPTH];

    logic [47:0]  cmd_queue [$];
    foot_target_t targets_due [$];
    int           queued_cmds = 0;
    int           accepted_cmds = 0;
    int           mismatch_count = 0;

    bit          cmd_taken = 1'b0;
    bit          leg_taken = 1'b0;
    bit          send_idle = 1'b0;
    bit          recv_idle = 1'b0;
    int unsigned cmd_gap = 0;
    int unsigned ready_hold = 0;

    trot_gait_foot_targets dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // Table entry k: sin(pi/2 * k/DEPTH) in Q16, from the degree-nine polynomial.
    function automatic int unsigned sine_q16(int k);
        u64_t   u;
        u64_t   u2;
        longint p;
        longint v;
        if (k >= DEPTH)
            return 65536;
        u  = (u64_t'(k) << 32) / u64_t'(DEPTH);
        u2 = (u * u) >> 32;
        p  = POLY_C9;
        p  = POLY_C7 + (p * longint'(u2)) / ONE_Q32;
        p  = POLY_C5 + (p * longint'(u2)) / ONE_Q32;
        p  = POLY_C3 + (p * longint'(u2)) / ONE_Q32;
        p  = POLY_C1 + (p * longint'(u2)) / ONE_Q32;
        v  = (p * longint'(u)) / ONE_Q46;
        if (v < 0)
            v = 0;
        if (v > 65536)
            v = 65536;
        return 32'(v);
    endfunction

    // Signed Q16 sine of a phase, folded onto the quarter-wave table.
    function automatic longint phase_sine(logic [PH_W-1:0] ph);
        logic [1:0] quad;
        int         idx;
        longint     mag;
        quad = ph[PH_W-1:PH_W-2];
        idx  = (int'(ph[PH_W-3:0]) * DEPTH) >> (PH_W - 2);
        if (idx > DEPTH)
            idx = DEPTH;
        mag = quad[0] ? longint'(sin_rom[DEPTH - idx]) : longint'(sin_rom[idx]);
        return quad[1] ? -mag : mag;
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // Advance the gait phase for one tick and queue its four leg targets.
    task automatic predict_foot_targets(logic [47:0] cmd);
        longint       fwd;
        longint       side;
        longint       yaw;
        longint       thr;
        longint       yaw_term;
        longint       s;
        longint       c;
        longint       x;
        longint       y;
        longint       z;
        logic [15:0]  ph;
        logic [15:0]  ph_cos;
        bit           moving;
        bit           right;
        foot_target_t t;
        fwd  = longint'($signed(cmd[15:0]));
        side = longint'($signed(cmd[31:16]));
        yaw  = longint'($signed(cmd[47:32]));
        thr  = longint'(gait_cfg.move_threshold);
        moving = ((fwd < 0) ? -fwd : fwd) > thr || ((side < 0) ? -side : side) > thr
                 || ((yaw < 0) ? -yaw : yaw) > thr;
        yaw_term = (yaw * longint'(gait_cfg.yaw_gain)) / ONE_Q12;
        gait_phase = moving ? gait_phase + gait_cfg.phase_step : 16'd0;

        for (int leg = 0; leg < 4; leg++)
        begin
            // Right front and left back run half a turn out of step.
            right  = (leg == 1 || leg == 3);
            ph     = (leg == 1 || leg == 2) ? gait_phase + 16'h8000 : gait_phase;
            ph_cos = ph + 16'h4000;
            s = phase_sine(ph);
            c = phase_sine(ph_cos);

            x = (-c * fwd * longint'(gait_cfg.stride_gain)) / ONE_Q28;
            x += right ? yaw_term : -yaw_term;
            y = (-c * side * longint'(gait_cfg.stride_gain)) / ONE_Q28;
            y += right ? -longint'(gait_cfg.side_offset) : longint'(gait_cfg.side_offset);
            z = longint'(gait_cfg.standing_height);
            if (moving && s > 0)
                z += (s * longint'(gait_cfg.lift_height)) / ONE_Q16;

            t.leg  = 2'(leg);
            t.x    = sat16(x);
            t.y    = sat16(y);
            t.z    = sat16(z);
            t.last = (2'(leg) == tgft_pkg::LEG_LAST);
            targets_due.push_back(t);
        end
    endtask

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic int unsigned pause_cycles(bit enable);
        return enable ? $urandom_range(0, 11) : 0;
    endfunction

    // Register word with random upper bits; the low bits are an extreme or random.
    function automatic logic [31:0] reg_word(int width, bit is_signed);
        logic [31:0] mask;
        logic [31:0] word;
        logic [31:0] low;
        mask = (32'd1 << width) - 1;
        word = $urandom();
        case ($urandom_range(0, 3))
            0:       low = is_signed ? (32'd1 << (width - 1)) : 32'd0;
            1:       low = is_signed ? (32'd1 << (width - 1)) - 1 : mask;
            default: low = word;
        endcase
        return (word & ~mask) | (low & mask);
    endfunction

    // Mostly moving commands of varied size, some standing still, some raw noise.
    function automatic logic [47:0] random_cmd();
        int unsigned pick;
        int          span;
        logic [15:0] f [3];
        pick = $urandom_range(0, 19);
        if (pick < 3)
            span = int'(gait_cfg.move_threshold);
        else if (pick < 6)
            span = -1;
        else
        begin
            case ($urandom_range(0, 3))
                0:       span = 256;
                1:       span = 4096;
                2:       span = 12288;
                default: span = 32767;
            endcase
        end
        for (int i = 0; i < 3; i++)
            f[i] = (span < 0) ? 16'($urandom())
                              : 16'(int'($urandom_range(0, 2 * span)) - span);
        return {f[2], f[1], f[0]};
    endfunction

    task automatic push_cmd(int fwd, int side, int yaw);
        cmd_queue.push_back({16'(yaw), 16'(side), 16'(fwd)});
        queued_cmds++;
    endtask

    // Wait until every command is taken and every leg beat has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_cmds != queued_cmds || targets_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            tgft_pkg::REG_STANDING_HEIGHT: gait_cfg.standing_height = value[15:0];
            tgft_pkg::REG_LIFT_HEIGHT:     gait_cfg.lift_height = value[14:0];
            tgft_pkg::REG_STRIDE_GAIN:     gait_cfg.stride_gain = value[15:0];
            tgft_pkg::REG_SIDE_OFFSET:     gait_cfg.side_offset = value[14:0];
            tgft_pkg::REG_YAW_GAIN:        gait_cfg.yaw_gain = value[15:0];
            tgft_pkg::REG_PHASE_STEP:      gait_cfg.phase_step = value[15:0];
            tgft_pkg::REG_MOVE_THRESHOLD:  gait_cfg.move_threshold = value[14:0];
            default: ;
        endcase
    endtask

    // Command driver: one beat at a time, with a drawn gap after each accepted beat.
    always @(negedge clk)
    begin : drive_cmd
        int unsigned wait_n;
        if (rst_n && !(s_tvalid && !cmd_taken))
        begin
            wait_n = cmd_taken ? pause_cycles(send_idle) : cmd_gap;
            if (wait_n > 0)
            begin
                s_tvalid <= 1'b0;
                cmd_gap  <= wait_n - 1;
            end
            else if (cmd_queue.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= cmd_queue.pop_front();
                cmd_gap  <= 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
                cmd_gap  <= 0;
            end
        end
    end

    // Leg beat sink: a drawn stall after each beat, random ready while empty.
    always @(negedge clk)
    begin : drive_ready
        int unsigned wait_n;
        if (rst_n)
        begin
            wait_n = leg_taken ? pause_cycles(recv_idle) : ready_hold;
            if (wait_n > 0)
            begin
                m_tready   <= 1'b0;
                ready_hold <= wait_n - 1;
            end
            else if (!m_tvalid && recv_idle)
                m_tready <= ($urandom_range(0, 1) == 1);
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: compare leg beats with the oldest target, predict on command beats.
    always @(posedge clk)
    begin : watch_beats
        foot_target_t want;
        if (rst_n)
        begin
            cmd_taken <= s_tvalid && s_tready;
            leg_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                if (targets_due.size() == 0)
                begin
                    $error("leg beat with no target pending");
                    mismatch_count++;
                end
                else
                begin
                    want = targets_due.pop_front();
                    check_field("leg_index", want.leg, m_tuser);
                    check_field("foot_x", want.x, $signed(m_tdata[15:0]));
                    check_field("foot_y", want.y, $signed(m_tdata[31:16]));
                    check_field("foot_z", want.z, $signed(m_tdata[47:32]));
                    check_field("last_leg", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_foot_targets(s_tdata);
                accepted_cmds++;
            end
        end
    end

    initial
    begin
        for (int k = 0; k <= DEPTH; k++)
            sin_rom[k] = sine_q16(k);
        gait_cfg.standing_height = tgft_pkg::STANDING_HEIGHT_RST;
        gait_cfg.lift_height     = tgft_pkg::LIFT_HEIGHT_RST;
        gait_cfg.stride_gain     = tgft_pkg::STRIDE_GAIN_RST;
        gait_cfg.side_offset     = tgft_pkg::SIDE_OFFSET_RST;
        gait_cfg.yaw_gain        = tgft_pkg::YAW_GAIN_RST;
        gait_cfg.phase_step      = tgft_pkg::PHASE_STEP_RST;
        gait_cfg.move_threshold  = tgft_pkg::MOVE_THRESHOLD_RST;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings, back to back: threshold edges, extreme commands,
        // a short walk and a return to standing, which clears the phase.
        push_cmd(0, 0, 0);
        push_cmd(41, 0, 0);
        push_cmd(42, 0, 0);
        push_cmd(0, -41, -42);
        push_cmd(-32768, 0, 0);
        push_cmd(32767, 32767, 32767);
        push_cmd(-32768, -32768, -32768);
        repeat (3) push_cmd(4096, 0, 0);
        push_cmd(0, 4096, 0);
        push_cmd(0, 0, -4096);
        push_cmd(0, 0, 0);
        wait_drained();

        // Upper extremes with a zero threshold.
        write_reg(tgft_pkg::REG_STANDING_HEIGHT, 32'h0000_7FFF);
        write_reg(tgft_pkg::REG_LIFT_HEIGHT, 32'h0000_7FFF);
        write_reg(tgft_pkg::REG_STRIDE_GAIN, 32'h0000_FFFF);
        write_reg(tgft_pkg::REG_SIDE_OFFSET, 32'h0000_7FFF);
        write_reg(tgft_pkg::REG_YAW_GAIN, 32'h0000_FFFF);
        write_reg(tgft_pkg::REG_PHASE_STEP, 32'h0000_FFFF);
        write_reg(tgft_pkg::REG_MOVE_THRESHOLD, 32'h0000_0000);
        push_cmd(0, 0, 0);
        push_cmd(1, 0, 0);
        push_cmd(32767, -32768, 32767);
        wait_drained();

        // Lower extremes, a quarter-turn step and a top threshold; upper bits
        // of each word must be dropped, and the spare slot must do nothing.
        write_reg(tgft_pkg::REG_STANDING_HEIGHT, 32'hFFFF_8000);
        write_reg(tgft_pkg::REG_LIFT_HEIGHT, 32'hFFFF_8000);
        write_reg(tgft_pkg::REG_STRIDE_GAIN, 32'hFFFF_0000);
        write_reg(tgft_pkg::REG_SIDE_OFFSET, 32'h1234_8000);
        write_reg(tgft_pkg::REG_YAW_GAIN, 32'h8765_0000);
        write_reg(tgft_pkg::REG_PHASE_STEP, 32'hABCD_4000);
        write_reg(tgft_pkg::REG_MOVE_THRESHOLD, 32'hFFFF_7FFF);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        push_cmd(32767, -32767, 32767);
        push_cmd(-32768, 0, 0);
        wait_drained();

        // Quarter turns with full lift and stride: peaks and zero crossings.
        write_reg(tgft_pkg::REG_LIFT_HEIGHT, 32'h0000_7FFF);
        write_reg(tgft_pkg::REG_STRIDE_GAIN, 32'h0000_FFFF);
        write_reg(tgft_pkg::REG_MOVE_THRESHOLD, 32'h0000_0000);
        repeat (5) push_cmd(4096, -4096, 0);
        wait_drained();

        // Random settings and traffic; each phase drains before the next.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_reg(tgft_pkg::REG_STANDING_HEIGHT, reg_word(16, 1'b1));
            write_reg(tgft_pkg::REG_LIFT_HEIGHT, reg_word(15, 1'b0));
            write_reg(tgft_pkg::REG_STRIDE_GAIN, reg_word(16, 1'b0));
            write_reg(tgft_pkg::REG_SIDE_OFFSET, reg_word(15, 1'b0));
            write_reg(tgft_pkg::REG_YAW_GAIN, reg_word(16, 1'b0));
            write_reg(tgft_pkg::REG_PHASE_STEP, reg_word(16, 1'b0));
            if ($urandom_range(0, 3) == 0)
                write_reg(tgft_pkg::REG_MOVE_THRESHOLD, reg_word(15, 1'b0));
            else
                write_reg(tgft_pkg::REG_MOVE_THRESHOLD, $urandom_range(0, 300));
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            repeat (PHASE_TICKS)
            begin
                cmd_queue.push_back(random_cmd());
                queued_cmds++;
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tgft_pkg.sv
hdl/tgft_regs.sv
hdl/tgft_ctrl.sv
hdl/tgft_dp.sv
hdl/trot_gait_foot_targets.sv
test/trot_gait_foot_targets_tb.sv
